// ----- rtl/core/frame_hash_and_lit_bbox_unit_defines.svh -----
// Assertion macros shared by the frame hash and bounding box RTL.
// No dependencies; included by the controller and the datapath.
`ifndef FRAME_HASH_AND_LIT_BBOX_UNIT_DEFINES_SVH
`define FRAME_HASH_AND_LIT_BBOX_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define FHLB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FHLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fhlb_pkg.sv -----
// Shared types, constants and the FNV-1a fold for the frame hash unit.
// No dependencies; used by the controller, datapath, top level and testbench files.
`default_nettype none

package fhlb_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int EDGE_W    = 12;
  localparam int COUNT_W   = 25;
  localparam int SUM_W     = 48;
  localparam int HASH_W    = 64;
  localparam int CMP_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [HASH_W-1:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;
  // The 64-bit FNV prime is 2^40 + 0x1B3.
  localparam int                PRIME_SHIFT = 40;
  localparam logic [8:0]        PRIME_LOW   = 9'h1B3;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_SECOND,
    ST_THIRD
  } state_t;

  typedef enum logic [1:0] {
    SEL_FIRST,
    SEL_SECOND,
    SEL_THIRD
  } byte_sel_t;

  typedef struct packed {
    logic      accept;
    logic      fold;
    byte_sel_t sel;
    logic      publish;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic out_stall;
  } stat_t;

  typedef struct packed {
    logic [HASH_W-1:0]  frame_hash;
    logic [COUNT_W-1:0] lit_count;
    logic [SUM_W-1:0]   column_sum;
    logic [SUM_W-1:0]   row_sum;
    logic [EDGE_W-1:0]  left_edge;
    logic [EDGE_W-1:0]  top_edge;
    logic [EDGE_W-1:0]  right_edge;
    logic [EDGE_W-1:0]  bottom_edge;
    logic               any_lit;
  } res_t;

  // One FNV-1a step: xor the byte, multiply by the prime modulo 2^64.
  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {56'd0, b};
    return (x << PRIME_SHIFT) + (x * {55'd0, PRIME_LOW});
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fhlb_pix_if.sv -----
// Pixel channel: valid/ready handshake carrying three bytes in memory order.
// No dependencies.
`default_nettype none

interface fhlb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [7:0] byte_third;

  modport source (output valid, output byte_first, output byte_second,
                  output byte_third, input ready);
  modport sink (input valid, input byte_first, input byte_second,
                input byte_third, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fhlb_res_if.sv -----
// Result channel: valid/ready handshake carrying the per-frame summary.
// No dependencies.
`default_nettype none

interface fhlb_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_hash;
  logic [24:0] lit_count;
  logic [47:0] column_sum;
  logic [47:0] row_sum;
  logic [11:0] left_edge;
  logic [11:0] top_edge;
  logic [11:0] right_edge;
  logic [11:0] bottom_edge;
  logic        any_lit;

  modport source (output valid, output frame_hash, output lit_count,
                  output column_sum, output row_sum, output left_edge,
                  output top_edge, output right_edge, output bottom_edge,
                  output any_lit, input ready);
  modport sink (input valid, input frame_hash, input lit_count,
                input column_sum, input row_sum, input left_edge,
                input top_edge, input right_edge, input bottom_edge,
                input any_lit, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fhlb_ctrl.sv -----
// Sequencer for the frame hash unit: steps one pixel through three hash folds.
// Depends on fhlb_pkg and the assertion macro header.
`default_nettype none
`include "frame_hash_and_lit_bbox_unit_defines.svh"

module fhlb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fhlb_pkg::stat_t stat,
  output fhlb_pkg::cmd_t      cmd
);

  fhlb_pkg::state_t state_r;
  fhlb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fhlb_pkg::ST_ACCEPT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.accept  = 1'b0;
    cmd.fold    = 1'b0;
    cmd.sel     = fhlb_pkg::SEL_FIRST;
    cmd.publish = 1'b0;
    case (state_r)
      fhlb_pkg::ST_ACCEPT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cmd.fold   = 1'b1;
          state_nxt  = fhlb_pkg::ST_SECOND;
        end
      end
      fhlb_pkg::ST_SECOND: begin
        cmd.fold  = 1'b1;
        cmd.sel   = fhlb_pkg::SEL_SECOND;
        state_nxt = fhlb_pkg::ST_THIRD;
      end
      fhlb_pkg::ST_THIRD: begin
        // at frame end, hold the last fold while the previous summary is still unread
        if (!(stat.frame_end && stat.out_stall)) begin
          cmd.fold    = 1'b1;
          cmd.sel     = fhlb_pkg::SEL_THIRD;
          cmd.publish = stat.frame_end;
          state_nxt   = fhlb_pkg::ST_ACCEPT;
        end
      end
      default: begin
        state_nxt = fhlb_pkg::ST_ACCEPT;
      end
    endcase
  end

  `FHLB_ASSERT_NEXT(a_accept_to_second, clk, rst_n, cmd.accept, state_r == fhlb_pkg::ST_SECOND, "accepted transaction did not advance to the second fold")
  `FHLB_ASSERT_NEXT(a_stall_holds, clk, rst_n, (state_r == fhlb_pkg::ST_THIRD) && stat.frame_end && stat.out_stall, state_r == fhlb_pkg::ST_THIRD, "sequencer left the final fold while the result was stalled")

endmodule

`default_nettype wire

// ----- rtl/core/fhlb_dpath.sv -----
// Datapath of the frame hash unit: hash register, lit statistics, raster
// position and the result register. Depends on fhlb_pkg and the macro header.
`default_nettype none
`include "frame_hash_and_lit_bbox_unit_defines.svh"

module fhlb_dpath #(
  parameter int XW = 12,
  parameter int YW = 12
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire fhlb_pkg::cmd_t cmd,
  output fhlb_pkg::stat_t     stat,
  input  wire logic [7:0]     in_byte_first,
  input  wire logic [7:0]     in_byte_second,
  input  wire logic [7:0]     in_byte_third,
  input  wire logic [XW-1:0]  width_last,
  input  wire logic [YW-1:0]  height_last,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fhlb_pkg::res_t      out_res
);

  logic [fhlb_pkg::HASH_W-1:0]  hash_r, hash_nxt, hash_fold;
  logic [fhlb_pkg::COUNT_W-1:0] tally_r, tally_nxt;
  logic [fhlb_pkg::SUM_W-1:0]   xsum_r, xsum_nxt, ysum_r, ysum_nxt;
  logic [fhlb_pkg::EDGE_W-1:0]  left_r, left_nxt, top_r, top_nxt;
  logic [fhlb_pkg::EDGE_W-1:0]  right_r, right_nxt, bottom_r, bottom_nxt;
  logic                         seen_r, seen_nxt;
  logic [XW-1:0]                col_r, col_nxt;
  logic [YW-1:0]                row_r, row_nxt;
  logic                         frame_end_r, frame_end_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [7:0]                   b2_r, b3_r;
  fhlb_pkg::res_t               res_r;

  logic [7:0]                   fold_byte;
  logic                         lit, row_end, frame_end;
  logic [fhlb_pkg::CMP_W-1:0]   x_c, y_c;

  assign x_c       = fhlb_pkg::CMP_W'(col_r);
  assign y_c       = fhlb_pkg::CMP_W'(row_r);
  assign lit       = (in_byte_first != 8'd0) || (in_byte_second != 8'd0) ||
                     (in_byte_third != 8'd0);
  assign row_end   = col_r >= width_last;
  assign frame_end = row_end && (row_r >= height_last);

  always_comb begin
    case (cmd.sel)
      fhlb_pkg::SEL_FIRST:  fold_byte = in_byte_first;
      fhlb_pkg::SEL_SECOND: fold_byte = b2_r;
      fhlb_pkg::SEL_THIRD:  fold_byte = b3_r;
      default:              fold_byte = 8'd0;
    endcase
  end

  assign hash_fold = fhlb_pkg::fnv_fold(hash_r, fold_byte);

  always_comb begin
    hash_nxt      = hash_r;
    tally_nxt     = tally_r;
    xsum_nxt      = xsum_r;
    ysum_nxt      = ysum_r;
    left_nxt      = left_r;
    top_nxt       = top_r;
    right_nxt     = right_r;
    bottom_nxt    = bottom_r;
    seen_nxt      = seen_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    frame_end_nxt = frame_end_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.fold) begin
      hash_nxt = hash_fold;
    end

    if (cmd.accept) begin
      frame_end_nxt = frame_end;
      if (lit) begin
        tally_nxt = tally_r + fhlb_pkg::COUNT_W'(1);
        xsum_nxt  = xsum_r + fhlb_pkg::SUM_W'(col_r);
        ysum_nxt  = ysum_r + fhlb_pkg::SUM_W'(row_r);
        if (x_c < fhlb_pkg::CMP_W'(left_r))   left_nxt   = x_c[fhlb_pkg::EDGE_W-1:0];
        if (y_c < fhlb_pkg::CMP_W'(top_r))    top_nxt    = y_c[fhlb_pkg::EDGE_W-1:0];
        if (x_c > fhlb_pkg::CMP_W'(right_r))  right_nxt  = x_c[fhlb_pkg::EDGE_W-1:0];
        if (y_c > fhlb_pkg::CMP_W'(bottom_r)) bottom_nxt = y_c[fhlb_pkg::EDGE_W-1:0];
        seen_nxt = 1'b1;
      end
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + YW'(1);
      end else begin
        col_nxt = col_r + XW'(1);
      end
    end

    // publish the summary and start the next frame from clean state
    if (cmd.publish) begin
      hash_nxt      = fhlb_pkg::HASH_BASIS;
      tally_nxt     = '0;
      xsum_nxt      = '0;
      ysum_nxt      = '0;
      left_nxt      = '1;
      top_nxt       = '1;
      right_nxt     = '0;
      bottom_nxt    = '0;
      seen_nxt      = 1'b0;
      frame_end_nxt = 1'b0;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= fhlb_pkg::HASH_BASIS;
      tally_r     <= '0;
      xsum_r      <= '0;
      ysum_r      <= '0;
      left_r      <= '1;
      top_r       <= '1;
      right_r     <= '0;
      bottom_r    <= '0;
      seen_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      frame_end_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hash_r      <= hash_nxt;
      tally_r     <= tally_nxt;
      xsum_r      <= xsum_nxt;
      ysum_r      <= ysum_nxt;
      left_r      <= left_nxt;
      top_r       <= top_nxt;
      right_r     <= right_nxt;
      bottom_r    <= bottom_nxt;
      seen_r      <= seen_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      frame_end_r <= frame_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      b2_r <= in_byte_second;
      b3_r <= in_byte_third;
    end
    if (cmd.publish) begin
      res_r.frame_hash  <= hash_fold;
      res_r.lit_count   <= tally_r;
      res_r.column_sum  <= xsum_r;
      res_r.row_sum     <= ysum_r;
      res_r.left_edge   <= seen_r ? left_r : '0;
      res_r.top_edge    <= seen_r ? top_r : '0;
      res_r.right_edge  <= seen_r ? right_r : '0;
      res_r.bottom_edge <= seen_r ? bottom_r : '0;
      res_r.any_lit     <= seen_r;
    end
  end

  assign stat.frame_end = frame_end_r;
  assign stat.out_stall = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_res        = res_r;

  `FHLB_ASSERT_NEXT(a_publish_sets_valid, clk, rst_n, cmd.publish, out_valid_r && (hash_r == fhlb_pkg::HASH_BASIS) && !seen_r, "publish did not load the result and clear the frame state")
  `FHLB_ASSERT_NOW(a_unlit_means_no_tally, clk, rst_n, !seen_r, (tally_r == '0) && (xsum_r == '0) && (ysum_r == '0), "lit statistics moved without a lit pixel")

endmodule

`default_nettype wire

// ----- rtl/core/frame_hash_and_lit_bbox_unit.sv -----
// Frame hash and lit-pixel bounding box unit, top level.
// Uses fhlb_pkg, fhlb_pix_if, fhlb_res_if, fhlb_ctrl and fhlb_dpath.
//
// Usage: pixels arrive on in_pix in raster order, x fastest, three bytes
// each in memory order. Every pixel feeds a 64-bit FNV-1a hash; a pixel
// with any nonzero byte is lit and updates count, coordinate sums and the
// bounding box. With the last pixel of a frame (frame size from the
// cfg_ port: index 0 width, index 1 height; zero reads as one, oversize
// clamps to MAX_WIDTH / MAX_HEIGHT) one summary goes out on out_res.
// Write configuration only while no pixel is in flight.
// A new pixel is taken only after the three chained folds of the last.
// Each byte takes one pass through the shared multiply-by-prime fold.
// out_res.valid is registered, set as the last pixel's final fold publishes.
// A stalled receiver holds the summary in the output register; pixels keep
// flowing until the next frame's last pixel, which waits in its final fold.
// Reset (rst_n, synchronous) restores width 640, height 480 and clears the
// hash, statistics, raster position and any pending summary.
`default_nettype none

module frame_hash_and_lit_bbox_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  fhlb_pix_if.sink                               in_pix,
  fhlb_res_if.source                             out_res,
  input  wire logic                              cfg_we,
  input  wire logic [fhlb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fhlb_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  logic [fhlb_pkg::CFG_W-1:0] width_r, height_r;
  logic [fhlb_pkg::CMP_W-1:0] width_ext, height_ext, width_cl, height_cl;
  logic [XW-1:0]              width_last;
  logic [YW-1:0]              height_last;

  fhlb_pkg::cmd_t  cmd;
  fhlb_pkg::stat_t stat;
  fhlb_pkg::res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= fhlb_pkg::WIDTH_RESET;
      height_r <= fhlb_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fhlb_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        fhlb_pkg::CFG_IDX_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp the frame size and form the last column / row index
  assign width_ext  = fhlb_pkg::CMP_W'(width_r);
  assign height_ext = fhlb_pkg::CMP_W'(height_r);

  always_comb begin
    if (width_ext == '0) begin
      width_cl = fhlb_pkg::CMP_W'(1);
    end else if (width_ext > fhlb_pkg::CMP_W'(MAX_WIDTH)) begin
      width_cl = fhlb_pkg::CMP_W'(MAX_WIDTH);
    end else begin
      width_cl = width_ext;
    end
    if (height_ext == '0) begin
      height_cl = fhlb_pkg::CMP_W'(1);
    end else if (height_ext > fhlb_pkg::CMP_W'(MAX_HEIGHT)) begin
      height_cl = fhlb_pkg::CMP_W'(MAX_HEIGHT);
    end else begin
      height_cl = height_ext;
    end
  end

  assign width_last  = XW'(width_cl - fhlb_pkg::CMP_W'(1));
  assign height_last = YW'(height_cl - fhlb_pkg::CMP_W'(1));

  fhlb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pix.valid),
    .in_ready (in_pix.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fhlb_dpath #(
    .XW (XW),
    .YW (YW)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_byte_first  (in_pix.byte_first),
    .in_byte_second (in_pix.byte_second),
    .in_byte_third  (in_pix.byte_third),
    .width_last     (width_last),
    .height_last    (height_last),
    .out_valid      (out_res.valid),
    .out_ready      (out_res.ready),
    .out_res        (res)
  );

  assign out_res.frame_hash  = res.frame_hash;
  assign out_res.lit_count   = res.lit_count;
  assign out_res.column_sum  = res.column_sum;
  assign out_res.row_sum     = res.row_sum;
  assign out_res.left_edge   = res.left_edge;
  assign out_res.top_edge    = res.top_edge;
  assign out_res.right_edge  = res.right_edge;
  assign out_res.bottom_edge = res.bottom_edge;
  assign out_res.any_lit     = res.any_lit;

endmodule

`default_nettype wire

// ----- dv/frame_hash_and_lit_bbox_unit_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for frame_hash_and_lit_bbox_unit: tracks register writes and pixel
// transactions, predicts each frame summary and compares it field by field.
// Depends on fhlb_pkg, fhlb_pix_if and fhlb_res_if.

module frame_hash_and_lit_bbox_unit_checker #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fhlb_pix_if                            pix,
  fhlb_res_if                            res,
  input  logic                           cfg_we,
  input  logic [fhlb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fhlb_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             pixel_count,
  output int                             summary_count,
  output int                             dark_count
);

  localparam logic [fhlb_pkg::HASH_W-1:0] HASH_MULT = 64'd1099511628211;

  logic [fhlb_pkg::CFG_W-1:0]   width_reg;
  logic [fhlb_pkg::CFG_W-1:0]   height_reg;
  logic [fhlb_pkg::HASH_W-1:0]  hash_acc;
  logic [fhlb_pkg::COUNT_W-1:0] lit_tally;
  logic [fhlb_pkg::SUM_W-1:0]   col_acc;
  logic [fhlb_pkg::SUM_W-1:0]   row_acc;
  logic [fhlb_pkg::EDGE_W-1:0]  box_l;
  logic [fhlb_pkg::EDGE_W-1:0]  box_t;
  logic [fhlb_pkg::EDGE_W-1:0]  box_r;
  logic [fhlb_pkg::EDGE_W-1:0]  box_b;
  logic                         seen_lit;
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  fhlb_pkg::res_t               summary_q[$];
  fhlb_pkg::res_t               want;
  int                           errors;
  int                           pixels;
  int                           summaries;
  int                           darks;

  initial begin
    errors    = 0;
    pixels    = 0;
    summaries = 0;
    darks     = 0;
  end

  function automatic int unsigned clamp_size(input logic [fhlb_pkg::CFG_W-1:0] v,
                                             input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  task automatic clear_frame();
    hash_acc  = fhlb_pkg::HASH_BASIS;
    lit_tally = '0;
    col_acc   = '0;
    row_acc   = '0;
    box_l     = '1;
    box_t     = '1;
    box_r     = '0;
    box_b     = '0;
    seen_lit  = 1'b0;
    col_pos   = 0;
    row_pos   = 0;
  endtask

  task automatic report_error(input string msg);
    $display("%0t checker: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val)
      report_error($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", field, got, exp_val));
  endtask

  // Fold one pixel into the frame state; queue a summary when it closes the frame.
  task automatic absorb_pixel(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2);
    int unsigned    w;
    int unsigned    h;
    int unsigned    x;
    int unsigned    y;
    logic           row_end;
    logic           frame_end;
    fhlb_pkg::res_t summary;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    x = col_pos;
    y = row_pos;
    // Use >= so a size shrunk mid-frame closes the row at the next pixel.
    row_end   = (x >= w - 1);
    frame_end = row_end && (y >= h - 1);
    hash_acc = (hash_acc ^ {56'd0, b0}) * HASH_MULT;
    hash_acc = (hash_acc ^ {56'd0, b1}) * HASH_MULT;
    hash_acc = (hash_acc ^ {56'd0, b2}) * HASH_MULT;
    if ({b0, b1, b2} != 24'd0) begin
      lit_tally = lit_tally + 1'b1;
      col_acc   = col_acc + x;
      row_acc   = row_acc + y;
      if (x < box_l) box_l = x[fhlb_pkg::EDGE_W-1:0];
      if (y < box_t) box_t = y[fhlb_pkg::EDGE_W-1:0];
      if (x > box_r) box_r = x[fhlb_pkg::EDGE_W-1:0];
      if (y > box_b) box_b = y[fhlb_pkg::EDGE_W-1:0];
      seen_lit = 1'b1;
    end
    if (!frame_end) begin
      if (row_end) begin
        col_pos = 0;
        row_pos = y + 1;
      end else begin
        col_pos = x + 1;
      end
    end else begin
      summary.frame_hash  = hash_acc;
      summary.lit_count   = lit_tally;
      summary.column_sum  = col_acc;
      summary.row_sum     = row_acc;
      summary.left_edge   = seen_lit ? box_l : '0;
      summary.top_edge    = seen_lit ? box_t : '0;
      summary.right_edge  = seen_lit ? box_r : '0;
      summary.bottom_edge = seen_lit ? box_b : '0;
      summary.any_lit     = seen_lit;
      summary_q.push_back(summary);
      clear_frame();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = fhlb_pkg::WIDTH_RESET;
      height_reg = fhlb_pkg::HEIGHT_RESET;
      clear_frame();
      summary_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fhlb_pkg::CFG_IDX_WIDTH:  width_reg = cfg_wdata;
          fhlb_pkg::CFG_IDX_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        absorb_pixel(pix.byte_first, pix.byte_second, pix.byte_third);
        pixels++;
      end
      if (res.valid && res.ready) begin
        if (summary_q.size() == 0) begin
          report_error($sformatf("summary with no frame pending, hash 0x%0h", res.frame_hash));
        end else begin
          want = summary_q.pop_front();
          check_field("frame_hash", res.frame_hash, want.frame_hash);
          check_field("lit_count", res.lit_count, want.lit_count);
          check_field("column_sum", res.column_sum, want.column_sum);
          check_field("row_sum", res.row_sum, want.row_sum);
          check_field("left_edge", res.left_edge, want.left_edge);
          check_field("top_edge", res.top_edge, want.top_edge);
          check_field("right_edge", res.right_edge, want.right_edge);
          check_field("bottom_edge", res.bottom_edge, want.bottom_edge);
          check_field("any_lit", res.any_lit, want.any_lit);
          summaries++;
          if (!want.any_lit) darks++;
        end
      end
    end
    pending       <= summary_q.size();
    fail_count    <= errors;
    pixel_count   <= pixels;
    summary_count <= summaries;
    dark_count    <= darks;
  end

endmodule

// ----- dv/frame_hash_and_lit_bbox_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for frame_hash_and_lit_bbox_unit: drives pixels and register
// writes under varying handshake pressure and gives the verdict.
// Depends on fhlb_pkg, fhlb_pix_if, fhlb_res_if and the checker module.

module frame_hash_and_lit_bbox_unit_tb;

  localparam int CLK_HALF       = 4;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ROUNDS  = 16;
  localparam int PRESSURE_ROUND = 6;
  localparam int WIDE_PIXELS    = 160;

  localparam logic [fhlb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [fhlb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;
  localparam logic [fhlb_pkg::CFG_W-1:0]     SIZE_OVER        = 13'h1FFF;
  localparam logic [fhlb_pkg::CFG_W-1:0]     WIDE_SIZE        = 13'd160;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [fhlb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fhlb_pkg::CFG_W-1:0]     cfg_wdata;
  logic                           hold_req;
  int                             src_idle_pct;
  int                             snk_stall_pct;
  int                             cycles = 0;
  int                             fail_count;
  int                             pending;
  int                             pixel_count;
  int                             summary_count;
  int                             dark_count;

  fhlb_pix_if pix_ch();
  fhlb_res_if res_ch();

  frame_hash_and_lit_bbox_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  frame_hash_and_lit_bbox_unit_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .pix           (pix_ch),
    .res           (res_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .pixel_count   (pixel_count),
    .summary_count (summary_count),
    .dark_count    (dark_count)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d summaries outstanding", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ch.ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      IDLE_SENDER:   begin src_idle_pct = 47; snk_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  snk_stall_pct = 47; end
      default:       begin src_idle_pct = 27; snk_stall_pct = 27; end
    endcase
  endtask

  task automatic write_reg(input logic [fhlb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fhlb_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pixel and return at the edge of its transaction.
  task automatic send_pixel(input logic [23:0] px);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.byte_first  <= px[23:16];
    pix_ch.byte_second <= px[15:8];
    pix_ch.byte_third  <= px[7:0];
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every predicted summary, then let the pipeline drain.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] random_pixel();
    logic [23:0] raw;
    int unsigned pick;
    raw  = 24'($urandom());
    pick = $urandom_range(9);
    if (pick < 4) return '0;
    if (pick == 4) return raw & (24'hFF << (8 * $urandom_range(2)));
    if (pick == 5) return 24'h1 << $urandom_range(23);
    return raw;
  endfunction

  function automatic logic [fhlb_pkg::CFG_W-1:0] random_size(input int unsigned hi);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return 13'd1;
    return fhlb_pkg::CFG_W'($urandom_range(hi, 2));
  endfunction

  initial begin
    int          n_items;
    logic [23:0] px;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= fhlb_pkg::CFG_IDX_WIDTH;
    cfg_wdata          <= '0;
    hold_req           <= 1'b0;
    pix_ch.valid       <= 1'b0;
    pix_ch.byte_first  <= '0;
    pix_ch.byte_second <= '0;
    pix_ch.byte_third  <= '0;
    set_idling(IDLE_NONE);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x2 frame with byte extremes; spare indexes must leave the size alone.
    write_reg(fhlb_pkg::CFG_IDX_WIDTH, 13'd3);
    write_reg(fhlb_pkg::CFG_IDX_HEIGHT, 13'd2);
    write_reg(CFG_IDX_SPARE_LO, 13'd1);
    write_reg(CFG_IDX_SPARE_HI, SIZE_OVER);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h010000);
    send_pixel(24'h000080);
    send_pixel(24'h000000);
    send_pixel(24'h000100);
    settle();

    // Zero sizes read as one: single-pixel frames, the first one dark.
    write_reg(fhlb_pkg::CFG_IDX_WIDTH, '0);
    write_reg(fhlb_pkg::CFG_IDX_HEIGHT, '0);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h800000);
    settle();

    // Oversize frame, then shrink it mid-frame so the row and frame close early.
    write_reg(fhlb_pkg::CFG_IDX_WIDTH, SIZE_OVER);
    write_reg(fhlb_pkg::CFG_IDX_HEIGHT, 13'd5000);
    send_pixel(24'h000000);
    send_pixel(24'h000001);
    send_pixel(24'h000000);
    send_pixel(24'h7F0000);
    send_pixel(24'h000000);
    settle();
    write_reg(fhlb_pkg::CFG_IDX_WIDTH, 13'd3);
    write_reg(fhlb_pkg::CFG_IDX_HEIGHT, 13'd2);
    send_pixel(24'h000000);
    send_pixel(24'h000000);
    send_pixel(24'h000002);
    send_pixel(24'h000000);
    settle();

    // One long row, lit at both ends.
    write_reg(fhlb_pkg::CFG_IDX_WIDTH, WIDE_SIZE);
    write_reg(fhlb_pkg::CFG_IDX_HEIGHT, 13'd1);
    for (int i = 0; i < WIDE_PIXELS; i++) begin
      if (i == 0 || i == WIDE_PIXELS - 1 || $urandom_range(63) == 0)
        px = 24'($urandom_range(24'hFFFFFF, 1));
      else
        px = '0;
      send_pixel(px);
    end
    settle();

    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      set_idling(idle_mode_t'(round % 4));
      if (round == PRESSURE_ROUND) begin
        // Tiny frames with the receiver held off: output fills and input backs up.
        write_reg(fhlb_pkg::CFG_IDX_WIDTH, 13'd2);
        write_reg(fhlb_pkg::CFG_IDX_HEIGHT, 13'd1);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        n_items = 60;
      end else begin
        if ($urandom_range(3) != 0) write_reg(fhlb_pkg::CFG_IDX_WIDTH, random_size(12));
        if ($urandom_range(3) != 0) write_reg(fhlb_pkg::CFG_IDX_HEIGHT, random_size(6));
        if ($urandom_range(4) == 0)
          write_reg($urandom_range(1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
                    fhlb_pkg::CFG_W'($urandom()));
        n_items = $urandom_range(95, 55);
      end
      repeat (n_items) send_pixel(random_pixel());
      settle();
    end

    $display("Run covered %0d pixels and %0d frame summaries (%0d with no lit pixel),",
             pixel_count, summary_count, dark_count);
    $display("including zero, oversize and mid-frame size changes and a long output stall.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
